// ===== sv/bde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and constants of the bounded deque engine.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int OP_W      = 3;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int FILL_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_LIST_ALL   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ===== sv/bounded_deque_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_engine_unit
// Double-ended queue of signed 32-bit values held in a ring-buffer memory.
// ----------------------------------------------------------------------------
// The block takes one request item at a time and returns its result items
// through a registered output. A push, or any request that reports empty or
// full, has its result registered on acceptance when the output register is
// free, else it waits in S_NOTE. A pop reads the entry memory, whose read
// result is registered, and S_POP then registers the entry as the result. A
// listing reads the front entry first, then offers one entry per cycle while
// out_ready stays high, since each entry is read from the single memory read
// port while the previous one is offered. A stalled output holds each step.
// A new request is taken in the cycle after the last result of the previous
// one is registered, even while that result still waits to be taken.
// Unknown operation codes are accepted and give no result.
module bounded_deque_engine_unit import bde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [OP_W-1:0]          in_operation,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STATUS_W-1:0]           out_status,
  output logic signed [DATA_W-1:0]      out_item_value,
  output logic [FILL_W-1:0]             out_fill_level,
  output logic                          out_last
);

  mem_ctl_t                   mem_ctl;
  logic [$clog2(DEPTH)-1:0]   wr_addr;
  logic signed [DATA_W-1:0]   wr_data;
  logic [$clog2(DEPTH)-1:0]   rd_addr;
  logic signed [DATA_W-1:0]   rd_data;

  bde_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_fill_level (out_fill_level),
    .out_last       (out_last),
    .mem_ctl        (mem_ctl),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  bde_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> out_last)
    else $error("Empty or full report is not the last item.");

  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_fill_level == FILL_W'(DEPTH)))
    else $error("Full report with a fill level below the depth.");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_fill_level == '0))
    else $error("Empty report with a nonzero fill level.");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_level <= FILL_W'(DEPTH)))
    else $error("Fill level above the depth.");

endmodule
`default_nettype wire

// ===== sv/bde_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_store
// Entry memory of the deque: one write port and one read port with a
// registered read result.
// ----------------------------------------------------------------------------
module bde_store import bde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire mem_ctl_t                   mem_ctl,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic signed [DATA_W-1:0]   wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic signed [DATA_W-1:0]        rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== sv/bde_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_ctrl
// Request sequencer: keeps the front index and the fill count, drives the
// entry memory and holds the registered result item.
// ----------------------------------------------------------------------------
module bde_ctrl import bde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [OP_W-1:0]            in_operation,
  input  wire logic signed [DATA_W-1:0]   in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [STATUS_W-1:0]             out_status,
  output logic signed [DATA_W-1:0]        out_item_value,
  output logic [FILL_W-1:0]               out_fill_level,
  output logic                            out_last,
  output mem_ctl_t                        mem_ctl,
  output logic [$clog2(DEPTH)-1:0]        wr_addr,
  output logic signed [DATA_W-1:0]        wr_data,
  output logic [$clog2(DEPTH)-1:0]        rd_addr,
  input  wire logic signed [DATA_W-1:0]   rd_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_NOTE,
    S_POP,
    S_LIST
  } state_t;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W + 1)'(DEPTH)) begin
      s = s - (IDX_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         front_r, front_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         lst_r, lst_nxt;
  status_t                  note_status_r, note_status_nxt;
  logic [CNT_W-1:0]         note_fill_r, note_fill_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_item_r, out_item_nxt;
  logic [CNT_W-1:0]         out_fill_r, out_fill_nxt;
  logic                     out_last_r, out_last_nxt;

  logic             accept;
  logic             out_free;
  logic             full;
  logic             empty;
  op_t              op;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] back_pos;
  logic [IDX_W-1:0] last_pos;
  logic [IDX_W-1:0] list_next;
  logic             list_done;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign op        = op_t'(in_operation);
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = ring_add(front_r, IDX_W'(1));
  assign back_pos  = ring_add(front_r, count_r[IDX_W-1:0]);
  assign last_pos  = ring_add(front_r, IDX_W'(count_r - 1'b1));
  assign list_next = ring_add(front_r, lst_r + 1'b1);
  assign list_done = ((CNT_W'(lst_r) + 1'b1) == count_r);

  always_comb begin
    logic             res_now;
    status_t          res_status;
    logic [CNT_W-1:0] res_fill;

    res_now         = 1'b0;
    res_status      = ST_OK;
    res_fill        = count_r;
    state_nxt       = state_r;
    front_nxt       = front_r;
    count_nxt       = count_r;
    lst_nxt         = lst_r;
    note_status_nxt = note_status_r;
    note_fill_nxt   = note_fill_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_item_nxt    = out_item_r;
    out_fill_nxt    = out_fill_r;
    out_last_nxt    = out_last_r;
    mem_ctl         = '0;
    wr_addr         = back_pos;
    wr_data         = in_value;
    rd_addr         = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              res_now = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                mem_ctl.wr_en = 1'b1;
                if (op == OP_PUSH_FRONT) begin
                  wr_addr   = front_dec;
                  front_nxt = front_dec;
                end
                count_nxt = count_r + 1'b1;
                res_fill  = count_r + 1'b1;
              end
            end
            OP_LIST_ALL: begin
              if (empty) begin
                res_now    = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = front_r;
                lst_nxt       = '0;
                state_nxt     = S_LIST;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                res_now    = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                mem_ctl.rd_en = 1'b1;
                if (op == OP_POP_FRONT) begin
                  rd_addr   = front_r;
                  front_nxt = front_inc;
                end else begin
                  rd_addr = last_pos;
                end
                count_nxt = count_r - 1'b1;
                state_nxt = S_POP;
              end
            end
            default: begin
            end
          endcase
          if (res_now) begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = res_status;
              out_item_nxt   = '0;
              out_fill_nxt   = res_fill;
              out_last_nxt   = 1'b1;
            end else begin
              note_status_nxt = res_status;
              note_fill_nxt   = res_fill;
              state_nxt       = S_NOTE;
            end
          end
        end
      end
      S_NOTE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = note_status_r;
          out_item_nxt   = '0;
          out_fill_nxt   = note_fill_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = rd_data;
          out_fill_nxt   = count_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = rd_data;
          out_fill_nxt   = count_r;
          out_last_nxt   = list_done;
          if (list_done) begin
            state_nxt = S_IDLE;
          end else begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = list_next;
            lst_nxt       = lst_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lst_r         <= lst_nxt;
    note_status_r <= note_status_nxt;
    note_fill_r   <= note_fill_nxt;
    out_status_r  <= out_status_nxt;
    out_item_r    <= out_item_nxt;
    out_fill_r    <= out_fill_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_item_value = out_item_r;
  assign out_fill_level = FILL_W'(out_fill_r);
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded deque engine.
// ----------------------------------------------------------------------------
// A short table of requests covers the empty and extreme cases. Random phases
// follow that fill the queue past full, keep it there, and drain it again.
// A shadow deque in the bench predicts the result items; table rows may
// carry their own expected result instead. Each accepted result is compared
// field by field against the oldest prediction. Both sides of the block idle
// in random bursts, and the final phase runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;
  import bde_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = DEPTH_DEF + 16;
  localparam int N_DIR        = 21;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic [FILL_W-1:0]        fill;
    logic                     last;
  } deque_result_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    status_t                  status;
    logic signed [DATA_W-1:0] item;
    logic [FILL_W-1:0]        fill;
  } request_row_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_operation = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_item_value;
  logic [FILL_W-1:0]        out_fill_level;
  logic                     out_last;

  logic signed [DATA_W-1:0] shadow_ring [DEPTH_DEF];
  int                       shadow_head = 0;
  int                       shadow_fill = 0;
  int                       peak_fill = 0;
  deque_result_t            awaited_results [$];
  deque_result_t            request_results [$];

  bit                       row_typed = 1'b0;
  deque_result_t            row_result;
  bit                       idle_on = 1'b0;
  int                       stall_left = 0;
  int                       quiet_cycles = 0;
  int                       err_count = 0;
  int                       items_taken = 0;
  int                       results_taken = 0;
  int                       full_seen = 0;
  int                       empty_seen = 0;

  request_row_t dir_rows [N_DIR] = '{
    '{OP_POP_FRONT,  32'sh0000_0000, 1'b1, ST_EMPTY, 32'sh0000_0000, 7'd0},
    '{OP_POP_BACK,   32'sh1234_5678, 1'b1, ST_EMPTY, 32'sh0000_0000, 7'd0},
    '{OP_LIST_ALL,   32'sh0000_0000, 1'b1, ST_EMPTY, 32'sh0000_0000, 7'd0},
    '{OP_UNUSED_LO,  32'shFFFF_FFFF, 1'b0, ST_OK,    32'sh0000_0000, 7'd0},
    '{OP_UNUSED_HI,  32'sh0000_0000, 1'b0, ST_OK,    32'sh0000_0000, 7'd0},
    '{OP_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b1, ST_OK,    32'sh0000_0000, 7'd1},
    '{OP_PUSH_BACK,  32'sh8000_0000, 1'b1, ST_OK,    32'sh0000_0000, 7'd2},
    '{OP_PUSH_FRONT, 32'shFFFF_FFFF, 1'b1, ST_OK,    32'sh0000_0000, 7'd3},
    '{OP_PUSH_BACK,  32'sh0000_0000, 1'b1, ST_OK,    32'sh0000_0000, 7'd4},
    '{OP_LIST_ALL,   32'sh0000_0000, 1'b0, ST_OK,    32'sh0000_0000, 7'd0},
    '{OP_POP_FRONT,  32'sh0000_0000, 1'b1, ST_OK,    32'shFFFF_FFFF, 7'd3},
    '{OP_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK,    32'sh0000_0000, 7'd2},
    '{OP_PUSH_BACK,  32'sh5555_5555, 1'b0, ST_OK,    32'sh0000_0000, 7'd0},
    '{OP_LIST_ALL,   32'sh0000_0000, 1'b0, ST_OK,    32'sh0000_0000, 7'd0},
    '{OP_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK,    32'sh5555_5555, 7'd2},
    '{OP_POP_BACK,   32'sh0000_0000, 1'b1, ST_OK,    32'sh8000_0000, 7'd1},
    '{OP_POP_FRONT,  32'sh0000_0000, 1'b1, ST_OK,    32'sh7FFF_FFFF, 7'd0},
    '{OP_POP_BACK,   32'sh0000_0000, 1'b1, ST_EMPTY, 32'sh0000_0000, 7'd0},
    '{OP_PUSH_BACK,  32'shAAAA_AAAA, 1'b0, ST_OK,    32'sh0000_0000, 7'd0},
    '{OP_LIST_ALL,   32'sh0000_0000, 1'b0, ST_OK,    32'sh0000_0000, 7'd0},
    '{OP_POP_FRONT,  32'sh0000_0000, 1'b0, ST_OK,    32'sh0000_0000, 7'd0}
  };

  bounded_deque_engine_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_item_value(out_item_value),
    .out_fill_level(out_fill_level),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int ring_slot(int offset);
    return (shadow_head + offset) % DEPTH_DEF;
  endfunction

  function automatic deque_result_t make_result(status_t st, logic signed [DATA_W-1:0] item,
                                                int fill, logic last);
    deque_result_t r;
    r.status = st;
    r.value  = item;
    r.fill   = fill[FILL_W-1:0];
    r.last   = last;
    return r;
  endfunction

  // Applies one request to the shadow deque and collects the results it causes.
  function automatic void deque_apply(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
    logic signed [DATA_W-1:0] item;
    request_results.delete();
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_fill == DEPTH_DEF) begin
          request_results.push_back(make_result(ST_FULL, '0, shadow_fill, 1'b1));
        end else begin
          if (op == OP_PUSH_FRONT) begin
            shadow_head = ring_slot(DEPTH_DEF - 1);
            shadow_ring[shadow_head] = val;
          end else begin
            shadow_ring[ring_slot(shadow_fill)] = val;
          end
          shadow_fill++;
          if (shadow_fill > peak_fill) peak_fill = shadow_fill;
          request_results.push_back(make_result(ST_OK, '0, shadow_fill, 1'b1));
        end
      end
      OP_LIST_ALL: begin
        if (shadow_fill == 0) begin
          request_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_fill; i++) begin
            request_results.push_back(make_result(ST_OK, shadow_ring[ring_slot(i)],
                                                  shadow_fill, i == shadow_fill - 1));
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_fill == 0) begin
          request_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          if (op == OP_POP_FRONT) begin
            item = shadow_ring[shadow_head];
            shadow_head = ring_slot(1);
          end else begin
            item = shadow_ring[ring_slot(shadow_fill - 1)];
          end
          shadow_fill--;
          request_results.push_back(make_result(ST_OK, item, shadow_fill, 1'b1));
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns tb_top mismatch: %s", $time, what);
    err_count++;
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_taken++;
        if (out_status == ST_FULL) full_seen++;
        if (out_status == ST_EMPTY) empty_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result item arrived with nothing outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_item_value !== want.value)
            report_mismatch($sformatf("item_value %0d, want %0d", out_item_value, want.value));
          if (out_fill_level !== want.fill)
            report_mismatch($sformatf("fill_level %0d, want %0d", out_fill_level, want.fill));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
        end
      end
      if (in_valid && in_ready) begin
        items_taken++;
        deque_apply(in_operation, in_value);
        if (row_typed) begin
          awaited_results.push_back(row_result);
        end else begin
          foreach (request_results[i]) awaited_results.push_back(request_results[i]);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
          $display("tb_top: no handshake for %0d cycles", QUIET_LIMIT);
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  // Result side: ready drops in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                           bit typed, deque_result_t typed_result);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    row_typed     = typed;
    row_result    = typed_result;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_op(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (r < 11) return OP_LIST_ALL;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh0000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3:       return 32'shFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(int count, int push_pct);
    deque_result_t unused;
    unused = make_result(ST_OK, '0, 0, 1'b0);
    repeat (count) send_item(pick_op(push_pct), pick_value(), 1'b0, unused);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n   <= 1'b1;
    idle_on  = 1'b1;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed,
                make_result(dir_rows[i].status, dir_rows[i].item, dir_rows[i].fill, 1'b1));
    end
    run_phase(30, 55);
    run_phase(100, 95);
    idle_on = 1'b0;
    run_phase(25, 50);
    idle_on = 1'b1;
    run_phase(85, 10);
    idle_on = 1'b0;
    run_phase(30, 50);
    @(negedge clk);
    in_valid <= 1'b0;
    row_typed = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d requests taken, %0d result items checked, deepest fill %0d",
             items_taken, results_taken, peak_fill);
    $display("tb_top: %0d full reports and %0d empty reports seen", full_seen, empty_seen);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
